/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the sequencer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, disabled while reset is asserted
`define SSCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that also holds through reset
`define SSCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSCS_ASSERT(lbl, clk, rstn, prop, msg)
`define SSCS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/sscs_pkg.sv */
// ----------------------------------------------------------------------------
// sscs_pkg
// shared types and constants of the stepper s-curve sequencer
// ----------------------------------------------------------------------------
package sscs_pkg;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_DIR   = 3'd3,
    ACT_LOAD  = 3'd4
  } action_t;

  localparam logic [1:0] REG_RAMP_LENGTH = 2'd0;
  localparam logic [1:0] REG_TOTAL_STEPS = 2'd1;
  localparam logic [1:0] REG_PULSE_MAX   = 2'd2;

  localparam logic [9:0]  RAMP_LENGTH_RESET = 10'd400;
  localparam logic [15:0] TOTAL_STEPS_RESET = 16'd10000;
  localparam logic [15:0] PULSE_MAX_RESET   = 16'd100;
  localparam logic [15:0] PULSE_LOW_RESET   = 16'd35;
  localparam logic [15:0] FREQ_RESET        = 16'd500;

  // floor(x*35/100) = floor(floor(x*7/4) / 5), /5 done by reciprocal
  localparam int unsigned LOW_RECIP = 104858;
  localparam int unsigned LOW_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  phase;
    logic        running;
    logic [15:0] pulse_width;
    logic        freq_updated;
  } item_t;

endpackage

/* hw/rtl/sscs_ram.sv */
// ----------------------------------------------------------------------------
// sscs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sscs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sscs_ctrl.sv */
// ----------------------------------------------------------------------------
// sscs_ctrl
// sequencer state, command decode, ramp table write and read issue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sscs_ctrl import sscs_pkg::*; #(
  parameter int RAMP_ENTRIES = 512,
  parameter int AW           = $clog2(RAMP_ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic [2:0]    action,
  input  logic [8:0]    entry_index,
  input  logic [15:0]   entry_freq,
  input  logic [9:0]    ramp_length,
  input  logic [15:0]   total_steps,
  input  logic [15:0]   pulse_max,
  input  logic [15:0]   pulse_low,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [15:0]   ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  output item_t         res
);

  logic [1:0]    phase_r, phase_nxt;
  logic          dir_r, dir_nxt;
  logic          run_r, run_nxt;
  logic          armed_r, armed_nxt;
  logic [9:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [15:0]   steps_r, steps_nxt;
  logic [10:0]   cnt_inc;
  logic [31:0]   idx_ext;
  logic          upd;

  assign cnt_inc = {1'b0, cnt_r} + 11'd1;
  assign idx_ext = 32'(entry_index);

  always_comb begin
    phase_nxt = phase_r;
    dir_nxt   = dir_r;
    run_nxt   = run_r;
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    steps_nxt = steps_r;
    upd       = 1'b0;
    ram_we    = 1'b0;
    if (in_accept) begin
      unique case (action)
        ACT_TICK: begin
          if (run_r) begin
            phase_nxt = dir_r ? phase_r + 2'd1 : phase_r - 2'd1;
            if (armed_r) begin
              if (cnt_inc <= {1'b0, ramp_length}) begin
                cnt_nxt  = cnt_inc[9:0];
                addr_nxt = (addr_r == AW'(RAMP_ENTRIES - 1)) ? '0 : addr_r + AW'(1);
                upd      = 1'b1;
              end else begin
                cnt_nxt   = '0;
                armed_nxt = 1'b0;
              end
            end
            steps_nxt = steps_r - 16'd1;
            if (steps_nxt == 16'd0) begin
              run_nxt = 1'b0;
            end
          end
        end
        ACT_START: begin
          armed_nxt = 1'b1;
          cnt_nxt   = '0;
          addr_nxt  = '0;
          run_nxt   = 1'b1;
          steps_nxt = total_steps;
        end
        ACT_STOP: begin
          run_nxt   = 1'b0;
          steps_nxt = '0;
        end
        ACT_DIR: begin
          dir_nxt = ~dir_r;
        end
        ACT_LOAD: begin
          ram_we = (idx_ext < RAMP_ENTRIES);
        end
        default: begin
        end
      endcase
      if (!run_nxt) begin
        phase_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      dir_r   <= 1'b0;
      run_r   <= 1'b0;
      armed_r <= 1'b0;
      cnt_r   <= '0;
      addr_r  <= '0;
      steps_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      dir_r   <= dir_nxt;
      run_r   <= run_nxt;
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
      addr_r  <= addr_nxt;
      steps_r <= steps_nxt;
    end
  end

  assign ram_waddr = idx_ext[AW-1:0];
  assign ram_wdata = entry_freq;
  assign ram_re    = upd;
  assign ram_raddr = addr_r;

  assign res.phase        = phase_nxt;
  assign res.running      = run_nxt;
  assign res.pulse_width  = run_nxt ? pulse_max : pulse_low;
  assign res.freq_updated = upd;

  `SSCS_ASSERT(a_phase_zero_stopped, clk, rst_n, !run_r |-> (phase_r == 2'd0),
               "phase not zero while stopped")
  `SSCS_ASSERT(a_read_needs_ramp, clk, rst_n, ram_re |-> (run_r && armed_r && in_accept),
               "ramp read without a running armed tick")

endmodule

/* hw/rtl/sscs_out.sv */
// ----------------------------------------------------------------------------
// sscs_out
// result skid stage, ramp data merge and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sscs_out import sscs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_accept,
  input  item_t       res,
  input  logic [15:0] ram_rdata,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  logic        s1_valid_r;
  item_t       s1_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [15:0] freq_r;
  logic [15:0] freq_sel;
  logic        s1_move;

  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || s1_move);
  assign freq_sel  = s1_r.freq_updated ? ram_rdata : freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      freq_r      <= FREQ_RESET;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_accept;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move && s1_valid_r) begin
        freq_r <= freq_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= res;
    end
    if (s1_move && s1_valid_r) begin
      out_data_r <= {4'b0, s1_r.freq_updated, freq_sel, s1_r.pulse_width,
                     s1_r.running, s1_r.phase};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SSCS_ASSERT(a_s1_holds, clk, rst_n,
               (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_r)),
               "stalled skid entry lost or changed")
  `SSCS_ASSERT(a_freq_loaded, clk, rst_n,
               (s1_move && s1_valid_r && s1_r.freq_updated) |=> (freq_r == $past(ram_rdata)),
               "ramp frequency not taken from table read")

endmodule

/* hw/rtl/stepper_s_curve_sequencer_core.sv */
// a result passes the skid register, then the output register, after its input beat is accepted
// throughput: one beat per cycle unless the output stalls; at most one ramp read per tick on the single read port
// a load beat writes the table at its accept edge, so a following tick reads the new word
// reset: synchronous active-low rst_n clears sequencer state and restores register defaults
// reset leaves the ramp table contents untouched; entries are valid once written
// ----------------------------------------------------------------------------
// stepper_s_curve_sequencer_core
// four-phase stepper sequencer with loadable s-curve ramp and step budget
// ----------------------------------------------------------------------------
module stepper_s_curve_sequencer_core import sscs_pkg::*; #(
  parameter int RAMP_ENTRIES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[8:0], entry_freq[24:9]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // phase[1:0], running[2], pulse_width[18:3],
                                  // step_freq[34:19], freq_updated[35]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(RAMP_ENTRIES);

  logic [9:0]    ramp_length_r;
  logic [15:0]   total_steps_r;
  logic [15:0]   pulse_max_r;
  logic [15:0]   pulse_low_r;
  logic          cfg_wr;
  logic [18:0]   pm7;
  logic [33:0]   low_prod;
  logic          in_accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  item_t         res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign pm7      = ({3'b0, cfg_pwdata[15:0]} << 3) - {3'b0, cfg_pwdata[15:0]};
  assign low_prod = {17'b0, pm7[18:2]} * 34'(LOW_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_length_r <= RAMP_LENGTH_RESET;
      total_steps_r <= TOTAL_STEPS_RESET;
      pulse_max_r   <= PULSE_MAX_RESET;
      pulse_low_r   <= PULSE_LOW_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_RAMP_LENGTH: ramp_length_r <= cfg_pwdata[9:0];
        REG_TOTAL_STEPS: total_steps_r <= cfg_pwdata[15:0];
        REG_PULSE_MAX: begin
          pulse_max_r <= cfg_pwdata[15:0];
          pulse_low_r <= 16'(low_prod >> LOW_SHIFT);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_RAMP_LENGTH: cfg_prdata = {22'b0, ramp_length_r};
      REG_TOTAL_STEPS: cfg_prdata = {16'b0, total_steps_r};
      REG_PULSE_MAX:   cfg_prdata = {16'b0, pulse_max_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  sscs_ctrl #(
    .RAMP_ENTRIES (RAMP_ENTRIES),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .action      (in_tuser),
    .entry_index (in_tdata[8:0]),
    .entry_freq  (in_tdata[24:9]),
    .ramp_length (ramp_length_r),
    .total_steps (total_steps_r),
    .pulse_max   (pulse_max_r),
    .pulse_low   (pulse_low_r),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .res         (res)
  );

  sscs_ram #(
    .WIDTH (16),
    .DEPTH (RAMP_ENTRIES),
    .AW    (AW)
  ) u_ramp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sscs_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .res        (res),
    .ram_rdata  (ram_rdata),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
